[src/skwf_pkg.sv]
// Shared types, constants and helpers for the six-kernel window filter.
// No dependencies; every other file of the block but skwf_fifo imports this package.
`default_nettype none

package skwf_pkg;

  // Frame limits and derived widths
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 5;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 12;
  localparam int HGT_W      = 13;
  localparam int IROW_W     = $clog2(MAX_HEIGHT + 3);
  localparam int OROW_W     = $clog2(MAX_HEIGHT);
  localparam int NUM_SLOTS  = 5;
  localparam int SLOT_W     = 3;

  // Configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
  localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

  // Queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  // Divide by five: multiply by reciprocal, exact for sums up to 1275
  localparam int RECIP_SH = 16;
  localparam int DIVP_W   = 25;
  localparam logic [DIVP_W-1:0] RECIP5 = 25'd13108;

  // Gaussian coefficients, Q.COEF_FRAC_BITS, rounded from weights in units of 1/250000
  localparam int COEF_FRAC_BITS = 16;
  localparam int KW = COEF_FRAC_BITS;
  localparam int GS_W = 11;
  localparam int PW = KW + GS_W;
  localparam int GW = PW + 3;
  localparam longint unsigned KA_L = ((longint'(120)   << COEF_FRAC_BITS) + 125000) / 250000;
  localparam longint unsigned KB_L = ((longint'(1253)  << COEF_FRAC_BITS) + 125000) / 250000;
  localparam longint unsigned KC_L = ((longint'(2736)  << COEF_FRAC_BITS) + 125000) / 250000;
  localparam longint unsigned KD_L = ((longint'(13054) << COEF_FRAC_BITS) + 125000) / 250000;
  localparam longint unsigned KE_L = ((longint'(28514) << COEF_FRAC_BITS) + 125000) / 250000;
  localparam longint unsigned KF_L = ((longint'(62279) << COEF_FRAC_BITS) + 125000) / 250000;
  localparam logic [KW-1:0] K_A = KW'(KA_L);
  localparam logic [KW-1:0] K_B = KW'(KB_L);
  localparam logic [KW-1:0] K_C = KW'(KC_L);
  localparam logic [KW-1:0] K_D = KW'(KD_L);
  localparam logic [KW-1:0] K_E = KW'(KE_L);
  localparam logic [KW-1:0] K_F = KW'(KF_L);

  // Per-item tag that travels with the pixel to the result
  typedef struct packed {
    logic              emit;
    logic              v3;
    logic              v5;
    logic              last;
    logic [OROW_W-1:0] row;
    logic [COL_W-1:0]  col;
  } tag_t;

  // Classified item between front and back
  typedef struct packed {
    logic [7:0]        pixel;
    logic              wr_en;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    tag_t              tag;
  } mid_t;

  // Result beat
  typedef struct packed {
    logic [7:0]        plus_mean;
    logic [7:0]        diag_mean;
    logic [7:0]        laplace_edge;
    logic [7:0]        sharpened;
    logic [7:0]        embossed;
    logic [7:0]        gauss_smooth;
    logic [OROW_W-1:0] centre_row;
    logic [COL_W-1:0]  centre_col;
    logic              frame_last;
  } res_t;

  // Ring slot arithmetic modulo five
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] k);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + {1'b0, k};
    if (t >= (SLOT_W+1)'(NUM_SLOTS)) begin
      t = t - (SLOT_W+1)'(NUM_SLOTS);
    end
    return t[SLOT_W-1:0];
  endfunction

  // Saturate a signed value to a byte
  function automatic logic [7:0] clamp_u8(input logic signed [13:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 14'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/skwf_fifo.sv]
// Small synchronous queue with occupancy count.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module skwf_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [DW-1:0]                  din_i,
  input  wire logic                           pop_i,
  output logic      [DW-1:0]                  dout_o,
  output logic                                full_o,
  output logic                                empty_o,
  output logic      [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

`default_nettype wire

[src/skwf_line_mem.sv]
// Five line buffers, one per ring slot, each one row of pixels.
// Depends on skwf_pkg for widths and slot count.
`default_nettype none

module skwf_line_mem
  import skwf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [SLOT_W-1:0]   wslot_i,
  input  wire logic [COL_W-1:0]    addr_i,
  input  wire logic [7:0]          wdata_i,
  input  wire logic                re_i,
  output logic      [7:0]          rdata_o [NUM_SLOTS]
);

  logic [7:0] mem_q [NUM_SLOTS][MAX_WIDTH];
  logic [7:0] rd_q  [NUM_SLOTS];

  assign rdata_o = rd_q;

  // Write one bank, read the same column of every bank
  for (genvar b = 0; b < NUM_SLOTS; b++) begin : g_bank
    always_ff @(posedge clk_i) begin
      if (we_i && (wslot_i == SLOT_W'(b))) begin
        mem_q[b][addr_i] <= wdata_i;
      end
      if (re_i) begin
        rd_q[b] <= mem_q[b][addr_i];
      end
    end
  end

endmodule

`default_nettype wire

[src/skwf_front.sv]
// Front end: frame geometry registers, raster counters and item classification.
// Depends on skwf_pkg for types and limits.
`default_nettype none

module skwf_front
  import skwf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic                  full_i,
  input  wire logic [7:0]            pixel_i,
  input  wire logic                  pad_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  output logic                       mid_push_o,
  output mid_t                       mid_o
);

  logic [WID_W-1:0]  w_q, w_d;
  logic [HGT_W-1:0]  h_q, h_d;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [IROW_W-1:0] in_row_q, in_row_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic              accept, in_frame, take, emit, v3, v5, last;
  logic [HGT_W-1:0]  r_h;
  logic [WID_W-1:0]  c_w, in_col_inc, out_col_inc, wv;
  logic [HGT_W-1:0]  hv;

  // Classify the beat
  always_comb begin
    accept   = push_i && !full_i;
    in_frame = (HGT_W'(in_row_q) < h_q);
    take     = accept && !(in_frame && pad_i);
    emit     = (in_row_q > IROW_W'(2)) ||
               ((in_row_q == IROW_W'(2)) && (in_col_q >= COL_W'(2)));
    r_h      = HGT_W'(out_row_q);
    c_w      = WID_W'(out_col_q);
    v3       = (r_h >= HGT_W'(1)) && ((r_h + HGT_W'(2)) <= h_q) &&
               (c_w >= WID_W'(1)) && ((c_w + WID_W'(2)) <= w_q);
    v5       = (r_h >= HGT_W'(2)) && ((r_h + HGT_W'(3)) <= h_q) &&
               (c_w >= WID_W'(2)) && ((c_w + WID_W'(3)) <= w_q);
    last     = (r_h == (h_q - HGT_W'(1))) && (c_w == (w_q - WID_W'(1)));
  end

  always_comb begin
    mid_push_o       = take;
    mid_o.pixel      = pixel_i;
    mid_o.wr_en      = in_frame;
    mid_o.col        = in_col_q;
    mid_o.slot       = slot_q;
    mid_o.tag.emit   = emit;
    mid_o.tag.v3     = v3;
    mid_o.tag.v5     = v5;
    mid_o.tag.last   = last;
    mid_o.tag.row    = out_row_q;
    mid_o.tag.col    = out_col_q;
  end

  // Advance raster counters; clamp and apply register writes
  always_comb begin
    w_d         = w_q;
    h_d         = h_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    slot_d      = slot_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    in_col_inc  = WID_W'(in_col_q) + WID_W'(1);
    out_col_inc = WID_W'(out_col_q) + WID_W'(1);
    wv          = cfg_wdata_i[WID_W-1:0];
    hv          = cfg_wdata_i[HGT_W-1:0];

    if (take) begin
      if (in_col_inc >= w_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + IROW_W'(1);
        slot_d   = slot_add(slot_q, SLOT_W'(1));
      end else begin
        in_col_d = in_col_inc[COL_W-1:0];
      end
      if (emit) begin
        if (out_col_inc >= w_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + OROW_W'(1);
        end else begin
          out_col_d = out_col_inc[COL_W-1:0];
        end
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          slot_d    = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH: begin
          if (wv < WID_W'(MIN_DIM)) begin
            w_d = WID_W'(MIN_DIM);
          end else if (wv > WID_W'(MAX_WIDTH)) begin
            w_d = WID_W'(MAX_WIDTH);
          end else begin
            w_d = wv;
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (hv < HGT_W'(MIN_DIM)) begin
            h_d = HGT_W'(MIN_DIM);
          end else if (hv > HGT_W'(MAX_HEIGHT)) begin
            h_d = HGT_W'(MAX_HEIGHT);
          end else begin
            h_d = hv;
          end
        end
        default: begin
          w_d = w_q;
        end
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      slot_d    = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WIDTH_RESET;
      h_q       <= HEIGHT_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      slot_q    <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      slot_q    <= slot_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

`default_nettype wire

[src/skwf_back.sv]
// Back end: line buffer access, 5x5 window and the six-kernel arithmetic pipeline.
// Depends on skwf_pkg and skwf_line_mem.
`default_nettype none

module skwf_back
  import skwf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              mid_empty_i,
  input  wire mid_t              mid_i,
  output logic                   mid_pop_o,
  input  wire logic [OCNT_W-1:0] out_cnt_i,
  output logic                   out_push_o,
  output res_t                   out_o
);

  function automatic logic [GS_W-1:0] e11(input logic [7:0] v);
    return {3'b000, v};
  endfunction

  logic              issue;
  logic [7:0]        rd [NUM_SLOTS];

  logic              s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  tag_t              s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q;
  logic [7:0]        s1_pix_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic [7:0]        win_q [5][5];
  logic [7:0]        new_col [5];

  logic [GS_W-1:0]   ga_q, gb_q, gc_q, gd_q, ge_q, plus_q, diag_q, nb_q;
  logic [7:0]        ctr_q;
  logic [9:0]        epos_q, eneg_q;

  logic [PW-1:0]     pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic [DIVP_W-1:0] plus_p_q, diag_p_q;
  logic [7:0]        lap_q, shp_q, emb_q;

  logic [2:0]        inflight;
  logic [GW-1:0]     gsum, gshift;
  logic [7:0]        gbyte;
  logic signed [13:0] lap_s, shp_s, emb_s;

  // Issue only while the output queue has room for every beat in flight
  always_comb begin
    inflight  = 3'($countones({s1_vld_q && s1_tag_q.emit, s2_vld_q && s2_tag_q.emit,
                               s3_vld_q && s3_tag_q.emit, s4_vld_q && s4_tag_q.emit}));
    issue     = !mid_empty_i &&
                ((5'(out_cnt_i) + 5'(inflight)) < 5'(OUT_DEPTH));
    mid_pop_o = issue;
  end

  skwf_line_mem u_line_mem (
    .clk_i   (clk_i),
    .we_i    (issue && mid_i.wr_en),
    .wslot_i (mid_i.slot),
    .addr_i  (mid_i.col),
    .wdata_i (mid_i.pixel),
    .re_i    (issue),
    .rdata_o (rd)
  );

  // Order the new column oldest row first; the newest row is the pixel itself
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      new_col[i] = rd[slot_add(s1_slot_q, SLOT_W'(i + 1))];
    end
    new_col[4] = s1_pix_q;
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // Carry tags and shift the window
  always_ff @(posedge clk_i) begin
    s1_tag_q  <= mid_i.tag;
    s1_pix_q  <= mid_i.pixel;
    s1_slot_q <= mid_i.slot;
    s2_tag_q  <= s1_tag_q;
    s3_tag_q  <= s2_tag_q;
    s4_tag_q  <= s3_tag_q;
    if (s1_vld_q) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) begin
          win_q[i][j] <= win_q[i][j+1];
        end
        win_q[i][4] <= new_col[i];
      end
    end
  end

  // Window sums
  always_ff @(posedge clk_i) begin
    ga_q   <= e11(win_q[0][0]) + e11(win_q[0][4]) + e11(win_q[4][0]) + e11(win_q[4][4]);
    gb_q   <= e11(win_q[0][1]) + e11(win_q[0][3]) + e11(win_q[1][0]) + e11(win_q[1][4]) +
              e11(win_q[3][0]) + e11(win_q[3][4]) + e11(win_q[4][1]) + e11(win_q[4][3]);
    gc_q   <= e11(win_q[0][2]) + e11(win_q[2][0]) + e11(win_q[2][4]) + e11(win_q[4][2]);
    gd_q   <= e11(win_q[1][1]) + e11(win_q[1][3]) + e11(win_q[3][1]) + e11(win_q[3][3]);
    ge_q   <= e11(win_q[1][2]) + e11(win_q[2][1]) + e11(win_q[2][3]) + e11(win_q[3][2]);
    ctr_q  <= win_q[2][2];
    plus_q <= e11(win_q[1][2]) + e11(win_q[2][1]) + e11(win_q[2][2]) +
              e11(win_q[2][3]) + e11(win_q[3][2]);
    diag_q <= e11(win_q[0][0]) + e11(win_q[1][1]) + e11(win_q[2][2]) +
              e11(win_q[3][3]) + e11(win_q[4][4]);
    nb_q   <= e11(win_q[1][1]) + e11(win_q[1][2]) + e11(win_q[1][3]) + e11(win_q[2][1]) +
              e11(win_q[2][3]) + e11(win_q[3][1]) + e11(win_q[3][2]) + e11(win_q[3][3]);
    epos_q <= 10'(win_q[2][3]) + 10'(win_q[3][2]) + 10'(win_q[3][3]);
    eneg_q <= 10'(win_q[1][2]) + 10'(win_q[2][1]) + 10'(win_q[1][1]);
  end

  // Weight and saturate
  always_comb begin
    lap_s = $signed({3'b000, ctr_q, 3'b000}) - $signed({3'b000, nb_q});
    shp_s = $signed({3'b000, ctr_q, 3'b000} + {6'b000000, ctr_q}) -
            $signed({3'b000, nb_q});
    emb_s = $signed({4'b0000, epos_q}) - $signed({4'b0000, eneg_q});
  end

  always_ff @(posedge clk_i) begin
    pa_q     <= PW'(ga_q) * PW'(K_A);
    pb_q     <= PW'(gb_q) * PW'(K_B);
    pc_q     <= PW'(gc_q) * PW'(K_C);
    pd_q     <= PW'(gd_q) * PW'(K_D);
    pe_q     <= PW'(ge_q) * PW'(K_E);
    pf_q     <= PW'(ctr_q) * PW'(K_F);
    plus_p_q <= DIVP_W'(plus_q) * RECIP5;
    diag_p_q <= DIVP_W'(diag_q) * RECIP5;
    lap_q    <= clamp_u8(lap_s);
    shp_q    <= clamp_u8(shp_s);
    emb_q    <= clamp_u8(emb_s);
  end

  // Final sum, scale and border masks
  always_comb begin
    gsum   = GW'(pa_q) + GW'(pb_q) + GW'(pc_q) + GW'(pd_q) + GW'(pe_q) + GW'(pf_q);
    gshift = gsum >> COEF_FRAC_BITS;
    gbyte  = (gshift > GW'(255)) ? 8'd255 : gshift[7:0];

    out_push_o         = s4_vld_q && s4_tag_q.emit;
    out_o.plus_mean    = s4_tag_q.v3 ? plus_p_q[RECIP_SH+7:RECIP_SH] : 8'd0;
    out_o.laplace_edge = s4_tag_q.v3 ? lap_q : 8'd0;
    out_o.sharpened    = s4_tag_q.v3 ? shp_q : 8'd0;
    out_o.embossed     = s4_tag_q.v3 ? emb_q : 8'd0;
    out_o.diag_mean    = s4_tag_q.v5 ? diag_p_q[RECIP_SH+7:RECIP_SH] : 8'd0;
    out_o.gauss_smooth = s4_tag_q.v5 ? gbyte : 8'd0;
    out_o.centre_row   = s4_tag_q.row;
    out_o.centre_col   = s4_tag_q.col;
    out_o.frame_last   = s4_tag_q.last;
  end

endmodule

`default_nettype wire

[src/six_kernel_window_filter.sv]
// Six-kernel 5x5 window filter: one pixel beat per cycle while full is low, one
// result beat per pixel once 2*W+2 pixels of a frame are in. An accepted beat
// passes the mid queue, line buffer read, window, window sums and products in order;
// each takes one beat per cycle, so throughput is 1 beat/cycle while results drain.
// Reset clears counters and queues and sets the frame to 640x480; line buffers
// are not cleared (border results are forced to zero).
`default_nettype none

module six_kernel_window_filter
  import skwf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            pixel_i,
  input  wire logic                  pad_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [7:0]            plus_mean_o,
  output logic      [7:0]            diag_mean_o,
  output logic      [7:0]            laplace_edge_o,
  output logic      [7:0]            sharpened_o,
  output logic      [7:0]            embossed_o,
  output logic      [7:0]            gauss_smooth_o,
  output logic      [OROW_W-1:0]     centre_row_o,
  output logic      [COL_W-1:0]      centre_col_o,
  output logic                       frame_last_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i
);

  logic              mid_push, mid_full, mid_empty, mid_pop;
  mid_t              mid_in, mid_out;
  logic              out_push, out_full;
  logic [OCNT_W-1:0] out_cnt;
  res_t              res_in, res_out;

  assign full = mid_full;

  skwf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (mid_full),
    .pixel_i     (pixel_i),
    .pad_i       (pad_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mid_push_o  (mid_push),
    .mid_o       (mid_in)
  );

  skwf_fifo #(
    .DW    ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .din_i   (mid_in),
    .pop_i   (mid_pop),
    .dout_o  (mid_out),
    .full_o  (mid_full),
    .empty_o (mid_empty),
    .count_o ()
  );

  skwf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_i       (mid_out),
    .mid_pop_o   (mid_pop),
    .out_cnt_i   (out_cnt),
    .out_push_o  (out_push),
    .out_o       (res_in)
  );

  skwf_fifo #(
    .DW    ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .din_i   (res_in),
    .pop_i   (pop),
    .dout_o  (res_out),
    .full_o  (out_full),
    .empty_o (empty),
    .count_o (out_cnt)
  );

  // Present the oldest result beat; the credit check keeps the queue from overflowing
  always_comb begin
    plus_mean_o    = res_out.plus_mean;
    diag_mean_o    = res_out.diag_mean;
    laplace_edge_o = res_out.laplace_edge;
    sharpened_o    = res_out.sharpened;
    embossed_o     = res_out.embossed;
    gauss_smooth_o = res_out.gauss_smooth;
    centre_row_o   = res_out.centre_row;
    centre_col_o   = res_out.centre_col;
    frame_last_o   = res_out.frame_last && !(out_full && empty);
  end

endmodule

`default_nettype wire
